// ----- hdl/best_fit_heap_allocator_unit_macros.svh -----
// Assertion helpers for the allocator
`ifndef BEST_FIT_HEAP_ALLOCATOR_UNIT_MACROS_SVH
`define BEST_FIT_HEAP_ALLOCATOR_UNIT_MACROS_SVH

`define BFHA_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

`define BFHA_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`endif

// ----- hdl/bfha_pkg.sv -----
package bfha_pkg;

   localparam int ADDR_W           = 13;
   localparam int ARENA_BYTES      = 4096;
   localparam int HEADER_BYTES     = 16;
   localparam int MAX_SEGMENTS_DEF = 256;

   localparam logic CMD_ALLOC   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   localparam logic [1:0] ST_ALLOC   = 2'd0;
   localparam logic [1:0] ST_NOFIT   = 2'd1;
   localparam logic [1:0] ST_FREED   = 2'd2;
   localparam logic [1:0] ST_BADADDR = 2'd3;

   typedef logic [3:0] op_type;
   localparam op_type OP_NONE   = 4'd0;
   localparam op_type OP_INIT   = 4'd1;
   localparam op_type OP_LOAD   = 4'd2;
   localparam op_type OP_SCAN   = 4'd3;
   localparam op_type OP_DECIDE = 4'd4;
   localparam op_type OP_SHIFT  = 4'd5;
   localparam op_type OP_WRA    = 4'd6;
   localparam op_type OP_WRB    = 4'd7;
   localparam op_type OP_RDN    = 4'd8;
   localparam op_type OP_RDP    = 4'd9;
   localparam op_type OP_MERGE  = 4'd10;
   localparam op_type OP_RESP   = 4'd11;

   typedef struct packed {
      logic              used;
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] size;
   } seg_type;

   typedef struct packed {
      logic scan_done;
      logic shift_done;
      logic is_release;
      logic go;
      logic rsp_busy;
   } dp_status_type;

endpackage

// ----- hdl/best_fit_heap_allocator_unit.sv -----
// Best-fit heap allocator over a 4 KiB arena kept as an address-ordered
// segment table (one RAM, one write and one registered read per cycle).
// req channel: one transaction per allocate or release command.
// rsp channel: exactly one transaction per command, in order: status and
// the user offset of a new allocation (zero otherwise).
// Work per command: a full table scan over the N live segments, a table
// shift for the insert or the merge removals, and the fixed steps (WRA and
// WRB to allocate; RDN, RDP and MERGE to release). The scan and the shift
// both go through the one table port. One command is in flight at a time;
// req_tready is high only while idle, so a new command can be taken as soon
// as the previous result is registered.
// A finished result sits in the rsp register; if the receiver stalls, the
// block holds the result and waits before issuing the next one, but the
// new command is still taken and worked on meanwhile up to its result.
// Reset: synchronous, active high; after reset the INIT state writes entry 0
// of the table as a single free segment and req_tready then rises.
`include "best_fit_heap_allocator_unit_macros.svh"

module best_fit_heap_allocator_unit #(
   parameter int MAX_SEGMENTS = bfha_pkg::MAX_SEGMENTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [0] cmd, [13:1] req_size, [26:14] user_addr
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // [1:0] status, [14:2] result_addr
);

   localparam int CW = $clog2(MAX_SEGMENTS + 1);

   bfha_pkg::op_type                op;
   bfha_pkg::dp_status_type         stat;
   logic [1:0]                      rsp_status;
   logic [bfha_pkg::ADDR_W-1:0]     rsp_addr;
   logic [CW-1:0]                   seg_count;
   logic                            count_ok, addr_ok;

   bfha_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .op         (op)
   );

   bfha_dp #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .op         (op),
      .cmd        (req_tdata[0]),
      .req_size   (req_tdata[13:1]),
      .user_addr  (req_tdata[26:14]),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_status (rsp_status),
      .rsp_addr   (rsp_addr),
      .seg_count  (seg_count),
      .stat       (stat)
   );

   assign rsp_tdata = {1'b0, rsp_addr, rsp_status};

   assign count_ok = seg_count != '0 && seg_count <= CW'(MAX_SEGMENTS);
   assign addr_ok  = !rsp_tvalid || rsp_tdata[1:0] == bfha_pkg::ST_ALLOC ||
                     rsp_tdata[14:2] == '0;

   `BFHA_ASSERT_NEXT(a_single_cmd, req_tvalid && req_tready, !req_tready, "second command taken")
   `BFHA_ASSERT_ALWAYS(a_count_range, count_ok, "segment count out of range")
   `BFHA_ASSERT_ALWAYS(a_addr_zero, addr_ok, "address on failed transaction")

endmodule

// ----- hdl/bfha_ram.sv -----
module bfha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             we,
   input  logic [$clog2(DEPTH)-1:0]         waddr,
   input  logic [WIDTH-1:0]                 wdata,
   input  logic [$clog2(DEPTH)-1:0]         raddr,
   output logic [WIDTH-1:0]                 rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ----- hdl/bfha_ctrl.sv -----
module bfha_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  bfha_pkg::dp_status_type     stat,
   output bfha_pkg::op_type            op
);

   localparam logic [3:0] S_INIT   = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_SCAN   = 4'd2;
   localparam logic [3:0] S_DECIDE = 4'd3;
   localparam logic [3:0] S_SHIFT  = 4'd4;
   localparam logic [3:0] S_WRA    = 4'd5;
   localparam logic [3:0] S_WRB    = 4'd6;
   localparam logic [3:0] S_RDN    = 4'd7;
   localparam logic [3:0] S_RDP    = 4'd8;
   localparam logic [3:0] S_MERGE  = 4'd9;
   localparam logic [3:0] S_RESP   = 4'd10;

   logic [3:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      op         = bfha_pkg::OP_NONE;
      req_tready = 1'b0;
      case (state_ff)
         S_INIT: begin
            op       = bfha_pkg::OP_INIT;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op       = bfha_pkg::OP_LOAD;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            op = bfha_pkg::OP_SCAN;
            if (stat.scan_done) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            op = bfha_pkg::OP_DECIDE;
            if (!stat.go) begin
               state_in = S_RESP;
            end else if (stat.is_release) begin
               state_in = S_RDN;
            end else begin
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            op = bfha_pkg::OP_SHIFT;
            if (stat.shift_done) begin
               state_in = stat.is_release ? S_RESP : S_WRA;
            end
         end
         S_WRA: begin
            op       = bfha_pkg::OP_WRA;
            state_in = S_WRB;
         end
         S_WRB: begin
            op       = bfha_pkg::OP_WRB;
            state_in = S_RESP;
         end
         S_RDN: begin
            op       = bfha_pkg::OP_RDN;
            state_in = S_RDP;
         end
         S_RDP: begin
            op       = bfha_pkg::OP_RDP;
            state_in = S_MERGE;
         end
         S_MERGE: begin
            op       = bfha_pkg::OP_MERGE;
            state_in = S_SHIFT;
         end
         S_RESP: begin
            if (!stat.rsp_busy) begin
               op       = bfha_pkg::OP_RESP;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

endmodule

// ----- hdl/bfha_dp.sv -----
module bfha_dp #(
   parameter int MAX_SEGMENTS = bfha_pkg::MAX_SEGMENTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bfha_pkg::op_type                  op,
   input  logic                              cmd,
   input  logic [bfha_pkg::ADDR_W-1:0]       req_size,
   input  logic [bfha_pkg::ADDR_W-1:0]       user_addr,
   input  logic                              rsp_tready,
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_status,
   output logic [bfha_pkg::ADDR_W-1:0]       rsp_addr,
   output logic [$clog2(MAX_SEGMENTS+1)-1:0] seg_count,
   output bfha_pkg::dp_status_type           stat
);

   localparam int AW = bfha_pkg::ADDR_W;
   localparam int IW = $clog2(MAX_SEGMENTS);
   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam int SW = $bits(bfha_pkg::seg_type);
   localparam logic [AW-1:0] HDR  = AW'(bfha_pkg::HEADER_BYTES);
   localparam logic [AW:0]   HDRW = (AW+1)'(bfha_pkg::HEADER_BYTES);

   logic              cmd_ff, cmd_in;
   logic [AW-1:0]     size_ff, size_in, uaddr_ff, uaddr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     scan_idx_ff, scan_idx_in;
   logic              scan_pend_ff, scan_pend_in;
   logic [IW-1:0]     scan_pidx_ff, scan_pidx_in;
   logic              found_ff, found_in;
   logic [IW-1:0]     best_ff, best_in;
   bfha_pkg::seg_type cur_ff, cur_in, nxt_ff, nxt_in;
   logic [CW-1:0]     sh_src_ff, sh_src_in, sh_left_ff, sh_left_in;
   logic              sh_ins_ff, sh_ins_in, sh_pend_ff, sh_pend_in;
   logic [1:0]        sh_dist_ff, sh_dist_in;
   logic [IW-1:0]     sh_dst_ff, sh_dst_in;
   logic [1:0]        res_status_ff, res_status_in;
   logic [AW-1:0]     res_addr_ff, res_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [AW-1:0]     rsp_addr_ff, rsp_addr_in;

   logic              ram_we;
   logic [IW-1:0]     ram_waddr, ram_raddr;
   bfha_pkg::seg_type ram_wdata, rdata;
   logic [SW-1:0]     rdata_raw;

   logic [AW:0]       need;
   logic [AW-1:0]     shrunk, pos, s1;
   logic              nxt_ok, nf, pf;
   logic [1:0]        drop_n;
   logic [CW-1:0]     src0, best_c;

   bfha_ram #(.WIDTH(SW), .DEPTH(MAX_SEGMENTS)) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (rdata_raw)
   );
   assign rdata = bfha_pkg::seg_type'(rdata_raw);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= CW'(1);
         scan_pend_ff <= 1'b0;
         sh_pend_ff   <= 1'b0;
         sh_left_ff   <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         scan_pend_ff <= scan_pend_in;
         sh_pend_ff   <= sh_pend_in;
         sh_left_ff   <= sh_left_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      size_ff       <= size_in;
      uaddr_ff      <= uaddr_in;
      scan_idx_ff   <= scan_idx_in;
      scan_pidx_ff  <= scan_pidx_in;
      best_ff       <= best_in;
      cur_ff        <= cur_in;
      nxt_ff        <= nxt_in;
      sh_src_ff     <= sh_src_in;
      sh_ins_ff     <= sh_ins_in;
      sh_dist_ff    <= sh_dist_in;
      sh_dst_ff     <= sh_dst_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   assign need   = {1'b0, size_ff} + HDRW;
   assign shrunk = cur_ff.size - need[AW-1:0];
   assign pos    = cur_ff.start + HDR + shrunk;
   assign best_c = CW'(best_ff);
   assign nxt_ok = (best_c + CW'(1)) < count_ff;
   assign nf     = nxt_ok && !nxt_ff.used;
   assign pf     = (best_ff != '0) && !rdata.used;
   assign s1     = nf ? (cur_ff.size + nxt_ff.size + HDR) : cur_ff.size;
   assign drop_n = {1'b0, nf} + {1'b0, pf};
   assign src0   = (pf && !nf) ? (best_c + CW'(1)) : (best_c + CW'(2));

   always_comb begin
      cmd_in        = cmd_ff;
      size_in       = size_ff;
      uaddr_in      = uaddr_ff;
      count_in      = count_ff;
      scan_idx_in   = scan_idx_ff;
      scan_pend_in  = scan_pend_ff;
      scan_pidx_in  = scan_pidx_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      cur_in        = cur_ff;
      nxt_in        = nxt_ff;
      sh_src_in     = sh_src_ff;
      sh_left_in    = sh_left_ff;
      sh_ins_in     = sh_ins_ff;
      sh_pend_in    = sh_pend_ff;
      sh_dist_in    = sh_dist_ff;
      sh_dst_in     = sh_dst_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = '0;
      ram_raddr     = '0;
      case (op)
         bfha_pkg::OP_INIT: begin
            ram_we    = 1'b1;
            ram_wdata = '{used: 1'b0, start: '0,
                          size: AW'(bfha_pkg::ARENA_BYTES - bfha_pkg::HEADER_BYTES)};
            count_in  = CW'(1);
         end
         bfha_pkg::OP_LOAD: begin
            cmd_in       = cmd;
            size_in      = req_size;
            uaddr_in     = user_addr;
            scan_idx_in  = '0;
            scan_pend_in = 1'b0;
            found_in     = 1'b0;
         end
         bfha_pkg::OP_SCAN: begin
            if (scan_pend_ff) begin
               if (cmd_ff == bfha_pkg::CMD_ALLOC) begin
                  if (!rdata.used && {1'b0, rdata.size} >= need &&
                      (!found_ff || rdata.size <= cur_ff.size)) begin
                     found_in = 1'b1;
                     best_in  = scan_pidx_ff;
                     cur_in   = rdata;
                  end
               end else if (!found_ff && rdata.used &&
                            ({1'b0, rdata.start} + HDRW) == {1'b0, uaddr_ff}) begin
                  found_in = 1'b1;
                  best_in  = scan_pidx_ff;
                  cur_in   = rdata;
               end
            end
            if (scan_idx_ff < count_ff) begin
               ram_raddr    = scan_idx_ff[IW-1:0];
               scan_pidx_in = scan_idx_ff[IW-1:0];
               scan_idx_in  = scan_idx_ff + CW'(1);
               scan_pend_in = 1'b1;
            end else begin
               scan_pend_in = 1'b0;
            end
         end
         bfha_pkg::OP_DECIDE: begin
            res_addr_in = '0;
            if (cmd_ff == bfha_pkg::CMD_RELEASE) begin
               res_status_in = bfha_pkg::ST_BADADDR;
            end else begin
               res_status_in = bfha_pkg::ST_NOFIT;
               sh_src_in     = count_ff - CW'(1);
               sh_left_in    = count_ff - CW'(1) - best_c;
               sh_ins_in     = 1'b1;
               sh_pend_in    = 1'b0;
            end
         end
         bfha_pkg::OP_SHIFT: begin
            if (sh_pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = sh_dst_ff;
               ram_wdata = rdata;
            end
            if (sh_left_ff != '0) begin
               ram_raddr  = sh_src_ff[IW-1:0];
               sh_pend_in = 1'b1;
               sh_dst_in  = sh_ins_ff ? IW'(sh_src_ff + CW'(1))
                                      : IW'(sh_src_ff - CW'(sh_dist_ff));
               sh_src_in  = sh_ins_ff ? (sh_src_ff - CW'(1)) : (sh_src_ff + CW'(1));
               sh_left_in = sh_left_ff - CW'(1);
            end else begin
               sh_pend_in = 1'b0;
            end
         end
         bfha_pkg::OP_WRA: begin
            ram_we    = 1'b1;
            ram_waddr = best_ff;
            ram_wdata = '{used: 1'b0, start: cur_ff.start, size: shrunk};
         end
         bfha_pkg::OP_WRB: begin
            ram_we        = 1'b1;
            ram_waddr     = best_ff + IW'(1);
            ram_wdata     = '{used: 1'b1, start: pos, size: size_ff};
            count_in      = count_ff + CW'(1);
            res_status_in = bfha_pkg::ST_ALLOC;
            res_addr_in   = pos + HDR;
         end
         bfha_pkg::OP_RDN: begin
            ram_raddr = best_ff + IW'(1);
         end
         bfha_pkg::OP_RDP: begin
            ram_raddr = best_ff - IW'(1);
            nxt_in    = rdata;
         end
         bfha_pkg::OP_MERGE: begin
            ram_we = 1'b1;
            if (pf) begin
               ram_waddr = best_ff - IW'(1);
               ram_wdata = '{used: 1'b0, start: rdata.start, size: rdata.size + s1 + HDR};
            end else begin
               ram_waddr = best_ff;
               ram_wdata = '{used: 1'b0, start: cur_ff.start, size: s1};
            end
            sh_ins_in  = 1'b0;
            sh_dist_in = drop_n;
            sh_src_in  = src0;
            sh_pend_in = 1'b0;
            sh_left_in = (drop_n != 2'd0 && count_ff > src0) ? (count_ff - src0) : '0;
            count_in   = count_ff - CW'(drop_n);
            res_status_in = bfha_pkg::ST_FREED;
            res_addr_in   = '0;
         end
         bfha_pkg::OP_RESP: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = res_status_ff;
            rsp_addr_in   = res_addr_ff;
         end
         default: begin
         end
      endcase
   end

   assign stat.scan_done  = (scan_idx_ff == count_ff) && !scan_pend_ff;
   assign stat.shift_done = (sh_left_ff == '0) && !sh_pend_ff;
   assign stat.is_release = cmd_ff;
   assign stat.go         = found_ff &&
                            (cmd_ff == bfha_pkg::CMD_RELEASE ||
                             count_ff != CW'(MAX_SEGMENTS));
   assign stat.rsp_busy   = rsp_valid_ff && !rsp_tready;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_addr   = rsp_addr_ff;
   assign seg_count  = count_ff;

endmodule
